### design/dcpc_pkg.sv
// ============================================================================
// dcpc_pkg
// Shared types and constants for the day cycle phase controller: sequencer
// states, day level ramp selection, phase event codes, register indexes.
// ============================================================================
`timescale 1ns / 1ps

package dcpc_pkg;

    // elapsed time and cycle period width
    localparam int TIME_W = 32;

    // seconds in a 24 hour day
    localparam int SECONDS_PER_DAY = 86400;
    localparam int TOD_W           = 17;

    // register index width and indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUNRISE_ST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUNRISE_END  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUNSET_ST    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUNSET_END   = 3'd7;

    // phase event codes
    localparam int EV_W = 3;
    localparam logic [EV_W-1:0] EV_NONE          = 3'd0;
    localparam logic [EV_W-1:0] EV_SUNRISE_START = 3'd1;
    localparam logic [EV_W-1:0] EV_SUNRISE_END   = 3'd2;
    localparam logic [EV_W-1:0] EV_SUNSET_START  = 3'd3;
    localparam logic [EV_W-1:0] EV_SUNSET_END    = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PH,
        ST_CALC,
        ST_EVAL,
        ST_DIV_LVL,
        ST_AZ_SETUP,
        ST_DIV_AZ,
        ST_FINISH
    } state_t;

    // which part of the day level trapezoid the phase sits on
    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_RISE,
        LVL_FULL,
        LVL_FALL
    } lvl_mode_t;

endpackage

### design/day_cycle_phase_controller_top.sv
// ============================================================================
// day_cycle_phase_controller_top
// Derives the day cycle phase from elapsed time and reports day and sun
// flags, lights crossings, sunrise / sunset events, day level, sun azimuth
// and time of day; every division runs on one shared restoring divider.
// ============================================================================
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_ready    | elapsed_ms
//  output   | out_valid / out_ready  | phase, is_day, sun_up, lights_off_event,
//           |                        | lights_on_event, phase_event, day_level,
//           |                        | azimuth, time_of_day_s
//  config   | cfg_wr_en              | cfg_index, cfg_wdata
//
//  each transaction runs the single restoring divider, one quotient bit per
//  cycle: modulo plus fraction, then day level (only when the phase sits on
//  a sunrise or sunset ramp), then azimuth. in_ready is high only while the
//  sequencer is idle; a finished result waits in the output register so the
//  next transaction can start. the final result load waits while the
//  previous result is still unaccepted. reset is asynchronous and restores
//  the register defaults and last phase.
// ============================================================================
`timescale 1ns / 1ps

module day_cycle_phase_controller_top
    import dcpc_pkg::*;
#(
    parameter int PHASE_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_W-1:0]     elapsed_ms,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PHASE_BITS-1:0] phase,
    output logic                  is_day,
    output logic                  sun_up,
    output logic                  lights_off_event,
    output logic                  lights_on_event,
    output logic [EV_W-1:0]       phase_event,
    output logic [PHASE_BITS:0]   day_level,
    output logic [PHASE_BITS:0]   azimuth,
    output logic [TOD_W-1:0]      time_of_day_s,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_wdata
);

    localparam int PB     = PHASE_BITS;
    localparam int DVD_W  = TIME_W + PB;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int PROD_W = PB + TOD_W;

    localparam logic [63:0] ONE64   = 64'd1 << PHASE_BITS;
    localparam logic [63:0] TENTH2  = (64'd2 * ONE64 + 64'd5) / 64'd10;
    localparam logic [63:0] TENTH3  = (64'd3 * ONE64 + 64'd5) / 64'd10;
    localparam logic [63:0] TENTH7  = (64'd7 * ONE64 + 64'd5) / 64'd10;
    localparam logic [63:0] TENTH8  = (64'd8 * ONE64 + 64'd5) / 64'd10;
    localparam logic [63:0] QUART1  = ONE64 / 64'd4;
    localparam logic [63:0] QUART3  = (ONE64 * 64'd3) / 64'd4;

    localparam logic [TIME_W-1:0] RST_PERIOD = TIME_W'(600000);
    localparam logic [PB-1:0]     RST_T2     = PB'(TENTH2);
    localparam logic [PB-1:0]     RST_T3     = PB'(TENTH3);
    localparam logic [PB-1:0]     RST_T7     = PB'(TENTH7);
    localparam logic [PB-1:0]     RST_T8     = PB'(TENTH8);
    localparam logic [PB-1:0]     RST_Q1     = PB'(QUART1);
    localparam logic [PB-1:0]     RST_Q3     = PB'(QUART3);

    localparam logic [PB:0]       ONE        = {1'b1, {PB{1'b0}}};
    localparam logic [CNT_W-1:0]  CNT_PH     = CNT_W'(DVD_W - 1);
    localparam logic [CNT_W-1:0]  CNT_FRAC   = CNT_W'(PB - 1);
    localparam logic [PROD_W-1:0] SEC_DAY    = PROD_W'(SECONDS_PER_DAY);

    // configuration registers
    logic [TIME_W-1:0] period_reg;
    logic [PB-1:0]     offset_reg;
    logic [PB-1:0]     day_start_reg;
    logic [PB-1:0]     day_end_reg;
    logic [PB-1:0]     rise_st_reg;
    logic [PB-1:0]     rise_end_reg;
    logic [PB-1:0]     set_st_reg;
    logic [PB-1:0]     set_end_reg;

    // sequencer and divider
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] dsr_reg;
    logic [PB-1:0]     q_reg;

    // per transaction results
    logic [PB-1:0]     last_phase_reg;
    logic [PB-1:0]     p_reg;
    logic              is_day_reg;
    logic              sun_up_reg;
    logic              off_ev_reg;
    logic              on_ev_reg;
    logic [EV_W-1:0]   ev_reg;
    lvl_mode_t         lvl_mode_reg;
    logic [PB:0]       level_reg;
    logic [TOD_W-1:0]  tod_reg;

    // output register
    logic              out_valid_reg;
    logic [PB-1:0]     phase_out_reg;
    logic              is_day_out_reg;
    logic              sun_up_out_reg;
    logic              off_out_reg;
    logic              on_out_reg;
    logic [EV_W-1:0]   ev_out_reg;
    logic [PB:0]       level_out_reg;
    logic [PB:0]       az_out_reg;
    logic [TOD_W-1:0]  tod_out_reg;

    logic in_fire;
    logic out_free;
    logic div_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign div_last = (cnt_reg == '0);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= RST_PERIOD;
            offset_reg    <= RST_T3;
            day_start_reg <= RST_Q1;
            day_end_reg   <= RST_Q3;
            rise_st_reg   <= RST_T2;
            rise_end_reg  <= RST_T3;
            set_st_reg    <= RST_T7;
            set_end_reg   <= RST_T8;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CYCLE_PERIOD: period_reg    <= cfg_wdata;
                CFG_START_OFFSET: offset_reg    <= cfg_wdata[PB-1:0];
                CFG_DAY_START:    day_start_reg <= cfg_wdata[PB-1:0];
                CFG_DAY_END:      day_end_reg   <= cfg_wdata[PB-1:0];
                CFG_SUNRISE_ST:   rise_st_reg   <= cfg_wdata[PB-1:0];
                CFG_SUNRISE_END:  rise_end_reg  <= cfg_wdata[PB-1:0];
                CFG_SUNSET_ST:    set_st_reg    <= cfg_wdata[PB-1:0];
                CFG_SUNSET_END:   set_end_reg   <= cfg_wdata[PB-1:0];
                default: ;
            endcase
        end
    end

    // shared restoring divider step, one quotient bit per cycle
    logic [TIME_W:0]   div_shift;
    logic [TIME_W+1:0] div_diff;
    logic              div_take;
    logic [TIME_W-1:0] rem_step;
    logic [PB-1:0]     q_step;

    always_comb
    begin
        div_shift = {rem_reg, dvd_reg[DVD_W-1]};
        div_diff  = {1'b0, div_shift} - {2'b00, dsr_reg};
        div_take  = !div_diff[TIME_W+1];
        rem_step  = div_take ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
        q_step    = {q_reg[PB-2:0], div_take};
    end

    // phase from fraction and offset; zero period leaves the fraction at zero
    logic [PB-1:0] frac;
    logic [PB-1:0] p_calc;

    always_comb
    begin
        frac   = (period_reg == '0) ? '0 : q_reg;
        p_calc = frac + offset_reg;
    end

    // flags, crossings, event priority, ramp selection, time of day
    logic              is_day_c;
    logic              sun_up_c;
    logic              off_c;
    logic              on_c;
    logic [EV_W-1:0]   ev_c;
    lvl_mode_t         lvl_c;
    logic [PROD_W-1:0] tod_prod;

    always_comb
    begin
        is_day_c = (p_reg >= day_start_reg) && (p_reg < day_end_reg);
        sun_up_c = (p_reg >= rise_st_reg) && (p_reg < set_end_reg);

        off_c = ((last_phase_reg < day_start_reg) && (p_reg >= day_start_reg))
             || ((last_phase_reg >= day_end_reg) && (p_reg < day_end_reg));
        on_c  = ((last_phase_reg < day_end_reg) && (p_reg >= day_end_reg))
             || ((last_phase_reg >= day_start_reg) && (p_reg < day_start_reg));

        if ((last_phase_reg < rise_st_reg) && (p_reg >= rise_st_reg))
            ev_c = EV_SUNRISE_START;
        else if ((last_phase_reg < rise_end_reg) && (p_reg >= rise_end_reg))
            ev_c = EV_SUNRISE_END;
        else if ((last_phase_reg < set_st_reg) && (p_reg >= set_st_reg))
            ev_c = EV_SUNSET_START;
        else if ((last_phase_reg < set_end_reg) && (p_reg >= set_end_reg))
            ev_c = EV_SUNSET_END;
        else
            ev_c = EV_NONE;

        if (p_reg < rise_st_reg)
            lvl_c = LVL_ZERO;
        else if (p_reg < rise_end_reg)
            lvl_c = LVL_RISE;
        else if (p_reg < set_st_reg)
            lvl_c = LVL_FULL;
        else if (p_reg < set_end_reg)
            lvl_c = LVL_FALL;
        else
            lvl_c = LVL_ZERO;

        tod_prod = {{TOD_W{1'b0}}, p_reg} * SEC_DAY;
    end

    // day level from ramp selection and ramp quotient
    logic [PB:0] level_c;

    always_comb
    begin
        case (lvl_mode_reg)
            LVL_RISE: level_c = {1'b0, q_reg};
            LVL_FULL: level_c = ONE;
            LVL_FALL: level_c = ONE - {1'b0, q_reg};
            default:  level_c = '0;
        endcase
    end

    // azimuth operands: sun arc while sun is up, night arc otherwise
    logic [PB:0] az_num;
    logic [PB:0] az_den;

    always_comb
    begin
        if (sun_up_reg)
        begin
            az_num = {1'b0, p_reg} - {1'b0, rise_st_reg};
            az_den = {1'b0, set_end_reg} - {1'b0, rise_st_reg};
        end
        else
        begin
            az_num = {1'b0, p_reg} - {1'b0, set_end_reg}
                   + ((p_reg < set_end_reg) ? ONE : '0);
            az_den = ONE - {1'b0, set_end_reg} + {1'b0, rise_st_reg};
        end
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_DIV_PH;
            ST_DIV_PH:   if (div_last) state_next = ST_CALC;
            ST_CALC:     state_next = ST_EVAL;
            ST_EVAL:
            begin
                if ((lvl_c == LVL_RISE) || (lvl_c == LVL_FALL))
                    state_next = ST_DIV_LVL;
                else
                    state_next = ST_AZ_SETUP;
            end
            ST_DIV_LVL:  if (div_last) state_next = ST_AZ_SETUP;
            ST_AZ_SETUP: state_next = ST_DIV_AZ;
            ST_DIV_AZ:   if (div_last) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // last phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_phase_reg <= RST_T3;
        else if (state_reg == ST_EVAL)
            last_phase_reg <= p_reg;
    end

    // divider operands and per transaction results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    dvd_reg <= {elapsed_ms, {PB{1'b0}}};
                    rem_reg <= '0;
                    dsr_reg <= period_reg;
                    cnt_reg <= CNT_PH;
                end
            end
            ST_DIV_PH, ST_DIV_LVL, ST_DIV_AZ:
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                rem_reg <= rem_step;
                q_reg   <= q_step;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_CALC:
            begin
                p_reg <= p_calc;
            end
            ST_EVAL:
            begin
                is_day_reg   <= is_day_c;
                sun_up_reg   <= sun_up_c;
                off_ev_reg   <= off_c;
                on_ev_reg    <= on_c;
                ev_reg       <= ev_c;
                lvl_mode_reg <= lvl_c;
                tod_reg      <= tod_prod[PROD_W-1:PB];
                dvd_reg      <= '0;
                cnt_reg      <= CNT_FRAC;
                if (lvl_c == LVL_FALL)
                begin
                    rem_reg <= TIME_W'(p_reg - set_st_reg);
                    dsr_reg <= TIME_W'(set_end_reg - set_st_reg);
                end
                else
                begin
                    rem_reg <= TIME_W'(p_reg - rise_st_reg);
                    dsr_reg <= TIME_W'(rise_end_reg - rise_st_reg);
                end
            end
            ST_AZ_SETUP:
            begin
                level_reg <= level_c;
                dvd_reg   <= '0;
                rem_reg   <= TIME_W'(az_num);
                dsr_reg   <= TIME_W'(az_den);
                cnt_reg   <= CNT_FRAC;
            end
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_FINISH) && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            phase_out_reg  <= p_reg;
            is_day_out_reg <= is_day_reg;
            sun_up_out_reg <= sun_up_reg;
            off_out_reg    <= off_ev_reg;
            on_out_reg     <= on_ev_reg;
            ev_out_reg     <= ev_reg;
            level_out_reg  <= level_reg;
            az_out_reg     <= {1'b0, q_reg};
            tod_out_reg    <= tod_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase            = phase_out_reg;
    assign is_day           = is_day_out_reg;
    assign sun_up           = sun_up_out_reg;
    assign lights_off_event = off_out_reg;
    assign lights_on_event  = on_out_reg;
    assign phase_event      = ev_out_reg;
    assign day_level        = level_out_reg;
    assign azimuth          = az_out_reg;
    assign time_of_day_s    = tod_out_reg;

    // an accepted transaction always starts the modulo division
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_DIV_PH))
        else $error("accepted transaction did not start the divider");

    // the azimuth division hands over to the result load
    a_az_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV_AZ) && div_last) |=> (state_reg == ST_FINISH))
        else $error("azimuth division did not end in result load");

    // a free output slot at result load always produces a valid result
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=> (out_valid_reg && in_ready))
        else $error("result load did not present a result");

    // only defined event codes reach the output
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ev_out_reg <= EV_SUNSET_END))
        else $error("undefined phase event code");

endmodule

### verif/dcpc_sky_checker.sv
// ============================================================================
// dcpc_sky_checker
// Watches the elapsed-time, result and register ports of the day cycle phase
// controller, predicts the sky state for every accepted tick and compares
// each accepted result, field by field, against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module dcpc_sky_checker
    import dcpc_pkg::*;
#(
    parameter int PHASE_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [TIME_W-1:0]     elapsed_ms,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic                  is_day,
    input  logic                  sun_up,
    input  logic                  lights_off_event,
    input  logic                  lights_on_event,
    input  logic [EV_W-1:0]       phase_event,
    input  logic [PHASE_BITS:0]   day_level,
    input  logic [PHASE_BITS:0]   azimuth,
    input  logic [TOD_W-1:0]      time_of_day_s,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_wdata,

    output int                    fail_count,
    output int                    pending
);

    localparam logic [63:0] ONE  = 64'd1 << PHASE_BITS;
    localparam logic [63:0] MASK = ONE - 64'd1;

    // one predicted or observed result
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  is_day;
        logic                  sun_up;
        logic                  lights_off;
        logic                  lights_on;
        logic [EV_W-1:0]       ev;
        logic [PHASE_BITS:0]   level;
        logic [PHASE_BITS:0]   az;
        logic [TOD_W-1:0]      tod;
    } sky_t;

    // shadow copy of the register file and the previous phase
    logic [63:0] period;
    logic [63:0] offset;
    logic [63:0] day_st;
    logic [63:0] day_nd;
    logic [63:0] rise_st;
    logic [63:0] rise_nd;
    logic [63:0] set_st;
    logic [63:0] set_nd;
    logic [63:0] last_ph;

    sky_t sky_due[$];
    int   fails;

    assign fail_count = fails;

    initial fails = 0;

    // fraction of one, rounded to nearest
    function automatic logic [63:0] tenths(input int n);
        return (64'(n) * ONE + 64'd5) / 64'd10;
    endfunction

    function automatic logic passes(input logic [63:0] was, input logic [63:0] now,
                                    input logic [63:0] mark);
        return (was < mark) && (now >= mark);
    endfunction

    // sky state for one tick, from the shadow registers and the previous phase
    function automatic sky_t predict_sky(input logic [TIME_W-1:0] tick);
        logic [63:0] t64;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] lvl;
        logic [63:0] az;
        logic [63:0] num;
        sky_t        s;
        t64  = 64'(tick);
        frac = 64'd0;
        if (period != 64'd0)
            frac = ((t64 % period) << PHASE_BITS) / period;
        p = (frac + offset) & MASK;

        s.phase      = p[PHASE_BITS-1:0];
        s.is_day     = (p >= day_st) && (p < day_nd);
        s.sun_up     = (p >= rise_st) && (p < set_nd);
        s.lights_off = passes(last_ph, p, day_st) || (last_ph >= day_nd && p < day_nd);
        s.lights_on  = passes(last_ph, p, day_nd) || (last_ph >= day_st && p < day_st);

        // first crossing in priority order wins
        if (passes(last_ph, p, rise_st))
            s.ev = EV_SUNRISE_START;
        else if (passes(last_ph, p, rise_nd))
            s.ev = EV_SUNRISE_END;
        else if (passes(last_ph, p, set_st))
            s.ev = EV_SUNSET_START;
        else if (passes(last_ph, p, set_nd))
            s.ev = EV_SUNSET_END;
        else
            s.ev = EV_NONE;

        // trapezoid: zero, rising ramp, full, falling ramp, zero
        if (p < rise_st)
            lvl = 64'd0;
        else if (p < rise_nd)
            lvl = ((p - rise_st) << PHASE_BITS) / (rise_nd - rise_st);
        else if (p < set_st)
            lvl = ONE;
        else if (p < set_nd)
            lvl = ONE - ((p - set_st) << PHASE_BITS) / (set_nd - set_st);
        else
            lvl = 64'd0;
        s.level = lvl[PHASE_BITS:0];

        // sun arc while up, night arc otherwise (night length wraps past one)
        if (s.sun_up)
            az = ((p - rise_st) << PHASE_BITS) / (set_nd - rise_st);
        else
        begin
            num = p - set_nd;
            if (p < set_nd)
                num = num + ONE;
            az = (num << PHASE_BITS) / (ONE + rise_st - set_nd);
        end
        s.az = az[PHASE_BITS:0];

        s.tod = TOD_W'((p * 64'(SECONDS_PER_DAY)) >> PHASE_BITS);
        return s;
    endfunction

    // monitor: results out, ticks in, register writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        sky_t want;
        sky_t got;
        if (!rst_n)
        begin
            period  <= 64'd600000;
            offset  <= tenths(3);
            day_st  <= ONE / 64'd4;
            day_nd  <= (ONE * 64'd3) / 64'd4;
            rise_st <= tenths(2);
            rise_nd <= tenths(3);
            set_st  <= tenths(7);
            set_nd  <= tenths(8);
            last_ph <= tenths(3);
            sky_due.delete();
            pending <= 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                got = {phase, is_day, sun_up, lights_off_event, lights_on_event,
                       phase_event, day_level, azimuth, time_of_day_s};
                if (sky_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with no tick outstanding, phase %0d",
                                 $realtime, phase);
                end
                else
                begin
                    want = sky_due.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $write("%0t: mismatch (exp/got) phase %0d/%0d day %0b/%0b ",
                                   $realtime, want.phase, got.phase,
                                   want.is_day, got.is_day);
                            $write("sun %0b/%0b off %0b/%0b on %0b/%0b ev %0d/%0d ",
                                   want.sun_up, got.sun_up,
                                   want.lights_off, got.lights_off,
                                   want.lights_on, got.lights_on, want.ev, got.ev);
                            $display("level %0d/%0d az %0d/%0d tod %0d/%0d",
                                     want.level, got.level, want.az, got.az,
                                     want.tod, got.tod);
                        end
                    end
                end
            end

            // tick transaction
            if (in_valid && in_ready)
            begin
                want = predict_sky(elapsed_ms);
                sky_due.push_back(want);
                last_ph <= 64'(want.phase);
            end

            // register write, phase registers keep their low bits only
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CYCLE_PERIOD: period  <= 64'(cfg_wdata);
                    CFG_START_OFFSET: offset  <= 64'(cfg_wdata) & MASK;
                    CFG_DAY_START:    day_st  <= 64'(cfg_wdata) & MASK;
                    CFG_DAY_END:      day_nd  <= 64'(cfg_wdata) & MASK;
                    CFG_SUNRISE_ST:   rise_st <= 64'(cfg_wdata) & MASK;
                    CFG_SUNRISE_END:  rise_nd <= 64'(cfg_wdata) & MASK;
                    CFG_SUNSET_ST:    set_st  <= 64'(cfg_wdata) & MASK;
                    CFG_SUNSET_END:   set_nd  <= 64'(cfg_wdata) & MASK;
                    default: ;
                endcase
            end

            pending <= sky_due.size();
        end
    end

endmodule

### verif/tb.sv
// ============================================================================
// tb
// Drives ticks of elapsed time into the day cycle phase controller under a
// series of register settings (reset values, ordered and scrambled marks,
// wrapping day, zero and extreme periods) with bursty input and a stalling
// result side, and reports the verdict from the checker's failure count.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import dcpc_pkg::*;

    localparam int PB         = 16;
    localparam int IDLE_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [TIME_W-1:0]    elapsed_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [PB-1:0]        phase;
    logic                 is_day;
    logic                 sun_up;
    logic                 lights_off_event;
    logic                 lights_on_event;
    logic [EV_W-1:0]      phase_event;
    logic [PB:0]          day_level;
    logic [PB:0]          azimuth;
    logic [TOD_W-1:0]     time_of_day_s;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_wdata;

    int                   fail_count;
    int                   pending;
    logic                 hold_req;
    logic [TIME_W-1:0]    period_now;
    logic [TIME_W-1:0]    tick_q[$];

    day_cycle_phase_controller_top #(.PHASE_BITS(PB)) dut (.*);

    dcpc_sky_checker #(.PHASE_BITS(PB)) sky_check (.*);

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // one tick transaction: offer at the falling edge, hold until taken
    task automatic offer(input logic [TIME_W-1:0] tick);
        @(negedge clk);
        in_valid   <= 1'b1;
        elapsed_ms <= tick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // play the queued ticks in bursts with random gaps
    task automatic play_ticks();
        int burst;
        burst = 0;
        while (tick_q.size() > 0)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    pause($urandom_range(20, 120));
                else
                    pause($urandom_range(0, 6));
                burst = $urandom_range(1, 16);
            end
            offer(tick_q.pop_front());
            burst--;
        end
        pause(1);
    endtask

    // mostly steady forward steps through the cycle, some jumps back and noise
    task automatic queue_ticks(input int count);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] span;
        t    = $urandom;
        span = (period_now == '0) ? 32'hFFFF : (period_now >> 4) + 1;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0:       t = $urandom;
                1:       t = t - $urandom_range(1, span);
                default: t = t + $urandom_range(1, span);
            endcase
            tick_q.push_back(t);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_CYCLE_PERIOD)
            period_now = val;
    endtask

    // full register set; junk fills the unused upper bits of the phase registers
    task automatic set_sky(input logic [31:0] per, input logic [15:0] offs,
                           input logic [15:0] ds, input logic [15:0] de,
                           input logic [15:0] rs, input logic [15:0] re,
                           input logic [15:0] ss, input logic [15:0] se,
                           input logic junk);
        logic [31:0] hi;
        hi = junk ? ($urandom & 32'hFFFF_0000) : 32'd0;
        wait_drained();
        write_reg(CFG_CYCLE_PERIOD, per);
        write_reg(CFG_START_OFFSET, hi | offs);
        write_reg(CFG_DAY_START, hi | ds);
        write_reg(CFG_DAY_END, hi | de);
        write_reg(CFG_SUNRISE_ST, hi | rs);
        write_reg(CFG_SUNRISE_END, hi | re);
        write_reg(CFG_SUNSET_ST, hi | ss);
        write_reg(CFG_SUNSET_END, hi | se);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ordered marks: sunrise start < sunrise end < sunset start < sunset end
    task automatic set_ordered(input logic [31:0] per, input logic junk);
        logic [15:0] rs, re, ss, se, ds, de;
        rs = 16'($urandom_range(0, 16000));
        re = rs + 16'($urandom_range(1, 8000));
        ss = re + 16'($urandom_range(1, 20000));
        se = ss + 16'($urandom_range(1, 8000));
        ds = 16'($urandom_range(0, 30000));
        de = ds + 16'($urandom_range(1, 30000));
        set_sky(per, 16'($urandom), ds, de, rs, re, ss, se, junk);
    endtask

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        elapsed_ms = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_CYCLE_PERIOD;
        cfg_wdata  = '0;
        hold_req   = 1'b0;
        period_now = 32'd600000;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: time extremes, then a sweep in twentieths of the
        // cycle that crosses every mark and wraps (both lights events at once)
        tick_q.push_back(32'd0);
        tick_q.push_back(32'hFFFF_FFFF);
        for (int k = 1; k <= 20; k++)
            tick_q.push_back(32'(k * 30000));
        play_ticks();

        // random settings
        set_ordered($urandom_range(1000, 2000000), 1'b0);
        queue_ticks(115);
        play_ticks();

        // shortest period: phase stuck at the offset, all marks at zero
        set_sky(32'd1, 16'($urandom), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        queue_ticks(15);
        play_ticks();

        // zero period, marks at the top, offset and sunrise start with upper bits set
        set_sky(32'd0, 16'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 1'b0);
        write_reg(CFG_START_OFFSET, 32'hFFFF_0000 | $urandom_range(0, 65535));
        write_reg(CFG_SUNRISE_ST, 32'hFFFF_FFFF);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        queue_ticks(15);
        play_ticks();

        // longest period, offset at the top; result side holds off meanwhile
        set_ordered(32'hFFFF_FFFF, 1'b1);
        write_reg(CFG_START_OFFSET, 32'h0000_FFFF);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        hold_req = 1'b1;
        queue_ticks(115);
        play_ticks();

        // scrambled marks, short period
        set_sky($urandom_range(1, 5000), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        queue_ticks(115);
        play_ticks();

        // day wraps past the cycle end, sunset ends near the top
        set_sky($urandom_range(1000, 100000), 16'($urandom),
                16'($urandom_range(40000, 65535)), 16'($urandom_range(0, 30000)),
                16'($urandom_range(0, 5000)), 16'($urandom_range(5001, 20000)),
                16'($urandom_range(20001, 60000)), 16'($urandom_range(60001, 65535)),
                1'b0);
        queue_ticks(115);
        play_ticks();

        // ordered marks with junk in the upper bits
        set_ordered($urandom_range(16, 1 << 24), 1'b1);
        queue_ticks(115);
        play_ticks();

        // back to the reset values
        set_sky(32'd600000, 16'd19661, 16'd16384, 16'd49152, 16'd13107,
                16'd19661, 16'd45875, 16'd52429, 1'b0);
        queue_ticks(115);
        play_ticks();

        // drain and let the pipeline settle
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: random stall pattern, one long hold-off on request
    initial
    begin : result_side
        int  left;
        int  pct;
        bit  held;
        left      = 0;
        pct       = 100;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
            end
            if (left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    pct = 100;
                    2:       pct = 70;
                    3:       pct = 30;
                    default: pct = 0;
                endcase
                left = (pct == 0) ? $urandom_range(30, 150) : $urandom_range(20, 300);
            end
            left--;
            out_ready <= ($urandom_range(1, 100) <= pct);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
